### sv/etfp_pkg.sv
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types and constants of the escape-time fractal pixel engine.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_JULIA_MODE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ZOOM = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OFF_RE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OFF_IM = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_JULIA_RE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_JULIA_IM = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_ITER_LIMIT = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd7;

    // complex value and iteration context passed between cells
    typedef struct packed {
        logic signed [31:0] zre;
        logic signed [31:0] zim;
        logic signed [31:0] cre;
        logic signed [31:0] cim;
    } etfp_val_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

### sv/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Mandelbrot / Julia escape-time engine for one pixel, signed Q4.28.
// ----------------------------------------------------------------------------
// Usage: an item on s_axis (tdata = pixel_x, pixel_y) starts one pixel. The
// coordinate is mapped and scaled in the ST_MAP state, then z = z*z + c runs
// round a chain of four cells, one iteration per pass round the chain. The result
// is held in a pending register until the output register is free, then
// moves to m_axis (tdata = escape_count, inside_set); s_axis is taken again
// once the output register is loaded.
// A run makes n passes round the chain, n the iterations run (escape index
// + 1, or iteration_limit). The block computes one pixel at a time: a new item
// is taken only once the last result is in the output register. A stalled
// receiver holds the result; the next item may be accepted and computed
// meanwhile, waiting in the pending register until the output register
// frees, and the input stalls until then.
// Reset clears the control and configuration registers to their defaults and empties the block.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// unknown indexes are ignored.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
    parameter int unsigned IMAGE_WIDTH  = 1024,
    parameter int unsigned IMAGE_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // pixel_x, pixel_y
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // escape_count, inside_set
    input  logic                            cfg_we,
    input  logic [etfp_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [etfp_pkg::CfgDataW-1:0]   cfg_data
);
    import etfp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // reciprocals of the image size: floor(p * 2^30 / size) = (p * RECIP) >> 22
    localparam logic [63:0] RECIP_W =
        ((64'd1 << 52) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH);
    localparam logic [63:0] RECIP_H =
        ((64'd1 << 52) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT);

    // configuration
    logic        julia_reg;
    logic [31:0] zoom_reg, off_re_reg, off_im_reg, jre_reg, jim_reg, thr_reg;
    logic [15:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            julia_reg <= 1'b0;
            zoom_reg <= 32'h1000_0000;
            off_re_reg <= '0;
            off_im_reg <= '0;
            jre_reg <= '0;
            jim_reg <= '0;
            limit_reg <= 16'd64;
            thr_reg <= 32'h4000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_JULIA_MODE: julia_reg <= cfg_data[0];
                REG_ZOOM:       zoom_reg <= cfg_data;
                REG_OFF_RE:     off_re_reg <= cfg_data;
                REG_OFF_IM:     off_im_reg <= cfg_data;
                REG_JULIA_RE:   jre_reg <= cfg_data;
                REG_JULIA_IM:   jim_reg <= cfg_data;
                REG_ITER_LIMIT: limit_reg <= cfg_data[15:0];
                REG_THRESHOLD:  thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    logic [1:0]  state_reg, state_next;
    logic [1:0]  map_cnt_reg;
    logic [15:0] iter_reg;
    logic        out_valid_reg;
    logic [15:0] out_cnt_reg;
    logic        out_in_reg;
    logic [15:0] res_cnt_reg;
    logic        res_in_reg;
    logic [9:0]  px_reg, py_reg;

    // mapping datapath
    logic signed [31:0] mre_reg, mim_reg;
    logic signed [63:0] sre_reg, sim_reg;
    etfp_val_t          seed_reg;

    // chain wiring: index 0 is the loop feed
    logic               cv [0:4];
    etfp_val_t          cval [0:4];
    logic [127:0]       caux [0:4];

    logic [63:0] mx_full, my_full;
    logic [42:0] mx_prod, my_prod;
    assign mx_full = 64'(px_reg) * RECIP_W;
    assign my_full = 64'(py_reg) * RECIP_H;
    assign mx_prod = {1'b0, mx_full[63:22]};
    assign my_prod = {1'b0, my_full[63:22]};

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    logic escaped, last_iter;
    assign escaped = cv[4] && caux[4][0];
    assign last_iter = (iter_reg + 16'd1 == limit_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MAP;
            ST_MAP:  if (map_cnt_reg == 2'd3)
                         state_next = (limit_reg == 16'd0) ? ST_DONE : ST_RUN;
            ST_RUN:  if (cv[4] && (caux[4][0] || last_iter)) state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // feed the chain: seed on entry, recirculate while running
    assign cv[0] = ((state_reg == ST_MAP) && (map_cnt_reg == 2'd3) && (limit_reg != 16'd0))
                   || ((state_reg == ST_RUN) && cv[4] && !caux[4][0] && !last_iter);
    assign cval[0] = (state_reg == ST_MAP) ? seed_reg : cval[4];
    assign caux[0] = '0;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_cell
            etfp_cell #(.PHASE(g)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .in_valid(cv[g]), .in_val(cval[g]), .in_aux(caux[g]),
                .threshold(thr_reg),
                .out_valid(cv[g+1]), .out_val(cval[g+1]), .out_aux(caux[g+1])
            );
        end
    endgenerate

    // phase 3 output carries its z in val, phase 1 result passes through 2
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= s_axis_tdata[9:0];
            py_reg <= s_axis_tdata[19:10];
        end
        mre_reg <= sat32(66'(signed'({21'd0, mx_prod})) - 66'sd536870912);
        mim_reg <= sat32(66'sd536870912 - 66'(signed'({21'd0, my_prod})));
        sre_reg <= 64'(mre_reg) * 64'(signed'({1'b0, zoom_reg}));
        sim_reg <= 64'(mim_reg) * 64'(signed'({1'b0, zoom_reg}));
        seed_reg.zre <= sat32(66'(sre_reg >>> 28) + 66'(signed'(off_re_reg)));
        seed_reg.zim <= sat32(66'(sim_reg >>> 28) + 66'(signed'(off_im_reg)));
        seed_reg.cre <= julia_reg ? signed'(jre_reg)
                        : sat32(66'(sre_reg >>> 28) + 66'(signed'(off_re_reg)));
        seed_reg.cim <= julia_reg ? signed'(jim_reg)
                        : sat32(66'(sim_reg >>> 28) + 66'(signed'(off_im_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            map_cnt_reg <= '0;
            iter_reg <= '0;
            out_valid_reg <= 1'b0;
            out_cnt_reg <= '0;
            out_in_reg <= 1'b0;
            res_cnt_reg <= '0;
            res_in_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MAP)
                map_cnt_reg <= map_cnt_reg + 2'd1;
            else
                map_cnt_reg <= '0;
            if (state_reg == ST_MAP)
                iter_reg <= '0;
            else if (cv[4])
                iter_reg <= iter_reg + 16'd1;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            else if (state_reg == ST_DONE && !out_valid_reg)
                out_valid_reg <= 1'b1;
            // capture the result on each pass out of the chain, or at once for a zero limit
            if (state_reg == ST_MAP && map_cnt_reg == 2'd3 && limit_reg == 16'd0)
            begin
                res_cnt_reg <= '0;
                res_in_reg <= 1'b1;
            end
            else if (state_reg == ST_RUN && cv[4])
            begin
                res_cnt_reg <= escaped ? iter_reg : 16'd0;
                res_in_reg <= !escaped;
            end
            // advance the pending result once the output register is free
            if (state_reg == ST_DONE && !out_valid_reg)
            begin
                out_cnt_reg <= res_cnt_reg;
                out_in_reg <= res_in_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_in_reg, out_cnt_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MAP))
        else $error("accept did not start mapping");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !cv[0] || (state_reg == ST_MAP))
        else $error("chain fed outside a run");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cv[1], cv[2], cv[3], cv[4]}) <= 1)
        else $error("more than one value in the chain");
endmodule

### sv/etfp_cell.sv
// ----------------------------------------------------------------------------
// etfp_cell
// One stage of the square pipe. Iteration z = z*z + c runs over four cells,
// with products formed in phases 0 and 2, registered at each hand-over.
// Phase 0: three 32x32 products. Phase 1: combine, saturate, add c.
// Phase 2: two squares of the new z. Phase 3: magnitude sum and compare.
// ----------------------------------------------------------------------------
module etfp_cell #(
    parameter int unsigned PHASE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  etfp_pkg::etfp_val_t  in_val,
    input  logic [127:0]         in_aux,
    input  logic [31:0]          threshold,
    output logic                 out_valid,
    output etfp_pkg::etfp_val_t  out_val,
    output logic [127:0]         out_aux
);
    import etfp_pkg::*;

    logic                valid_reg;
    etfp_val_t           val_reg, val_next;
    logic [127:0]        aux_reg, aux_next;
    logic signed [63:0]  p_rr, p_ii, p_ri;
    logic signed [65:0]  diff;
    logic [64:0]         mag;

    always_comb
    begin
        val_next = in_val;
        aux_next = in_aux;
        p_rr = 64'(in_val.zre) * 64'(in_val.zre);
        p_ii = 64'(in_val.zim) * 64'(in_val.zim);
        p_ri = 64'(in_val.zre) * 64'(in_val.zim);
        diff = 66'(signed'(in_aux[63:0])) - 66'(signed'(in_aux[127:64]));
        mag = 65'(in_aux[63:0]) + 65'(in_aux[127:64]);
        if (PHASE == 0)
        begin
            // hold re*re and im*im in aux, re*im in zre/zim pair
            aux_next = {p_ii, p_rr};
            val_next.zre = p_ri[63:32];
            val_next.zim = p_ri[31:0];
        end
        else if (PHASE == 1)
        begin
            val_next.zre = sat32(66'(diff >>> 28) + 66'(in_val.cre));
            val_next.zim = sat32(66'(signed'({in_val.zre, in_val.zim}) >>> 27)
                                 + 66'(in_val.cim));
        end
        else if (PHASE == 2)
        begin
            aux_next = {p_ii, p_rr};
        end
        else
        begin
            // escape flag in bit 0
            aux_next = {127'd0, (mag > {5'd0, threshold, 28'd0})};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        aux_reg <= aux_next;
    end

    assign out_valid = valid_reg;
    assign out_val = val_reg;
    assign out_aux = aux_reg;
endmodule

### sim/tb_escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel
// Self-checking testbench of the escape-time fractal pixel engine.
// Pixels go in on s_axis and escape results come out on m_axis. Both sides
// idle and stall at random. A predictor in the bench works out the expected
// escape index and in-set flag for each accepted pixel. The predictor keeps
// its own copy of the configuration registers. The tests cover directed
// extremes, iteration limits, Julia mode, back-pressure and random
// configuration phases.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel;
    timeunit 1ns;
    timeprecision 1ps;

    import etfp_pkg::*;

    localparam int unsigned STALL_LIMIT = 1200000;  // cycles with no item moving
    localparam int unsigned LONG_HOLD = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // pixel_x [9:0], pixel_y [19:10], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // escape_count [15:0], inside_set [16], zero fill
    logic        cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // bench copy of the configuration registers
    logic               mdl_julia;
    logic [31:0]        mdl_zoom;
    logic signed [31:0] mdl_off_re;
    logic signed [31:0] mdl_off_im;
    logic signed [31:0] mdl_jul_re;
    logic signed [31:0] mdl_jul_im;
    logic [15:0]        mdl_limit;
    logic [31:0]        mdl_thresh;

    logic [16:0] pending_escapes[$];  // {inside_set, escape_count} per pixel
    int          errors = 0;
    int unsigned idle_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          rx_long_hold = 1'b0;

    escape_time_fractal_pixel DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp to the signed 32-bit range.
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Map the pixel, scale it, then run z = z*z + c until |z|^2 passes the bound.
    function automatic logic [16:0] escape_of_pixel(input logic [9:0] px, input logic [9:0] py);
        longint      mre, mim, re, im, cre, cim, nre, nim;
        logic [63:0] are, aim, bound;
        int unsigned i;
        mre = clip32((longint'(px) <<< 20) - (64'sd1 <<< 29));
        mim = clip32((64'sd1 <<< 29) - (longint'(py) <<< 20));
        re = clip32(((mre * longint'(mdl_zoom)) >>> 28) + longint'(mdl_off_re));
        im = clip32(((mim * longint'(mdl_zoom)) >>> 28) + longint'(mdl_off_im));
        cre = mdl_julia ? longint'(mdl_jul_re) : re;
        cim = mdl_julia ? longint'(mdl_jul_im) : im;
        bound = {32'b0, mdl_thresh} << 28;
        for (i = 0; i < mdl_limit; i++)
        begin
            nre = clip32(((re * re - im * im) >>> 28) + cre);
            nim = clip32(((re * im) >>> 27) + cim);
            re = nre;
            im = nim;
            are = (re < 0) ? -re : re;
            aim = (im < 0) ? -im : im;
            if (are * are + aim * aim > bound)
                return {1'b0, i[15:0]};
        end
        return {1'b1, 16'd0};
    endfunction

    // Write one register; call only while the block is idle.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_JULIA_MODE: mdl_julia = value[0];
            REG_ZOOM:       mdl_zoom = value;
            REG_OFF_RE:     mdl_off_re = value;
            REG_OFF_IM:     mdl_off_im = value;
            REG_JULIA_RE:   mdl_jul_re = value;
            REG_JULIA_IM:   mdl_jul_im = value;
            REG_ITER_LIMIT: mdl_limit = value[15:0];
            REG_THRESHOLD:  mdl_thresh = value;
            default: ;
        endcase
    endtask

    // Offer one pixel; valid stays high afterwards so back-to-back items keep it up.
    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'b0, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_escapes.push_back(escape_of_pixel(px, py));
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain;
        s_axis_tvalid = 1'b0;
        wait (pending_escapes.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_random(input int count, input int px_lo, input int px_hi);
        for (int n = 0; n < count; n++)
            send_pixel(10'($urandom_range(px_hi, px_lo)), 10'($urandom_range(px_hi, px_lo)));
    endtask

    // Receiver: random stall per item, with an optional long hold-off.
    initial
    begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            m_axis_tready = 1'b0;
            repeat (gap) @(negedge clk);
            if (rx_long_hold)
            begin
                repeat (LONG_HOLD) @(negedge clk);
                rx_long_hold = 1'b0;
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        logic [16:0] exp_res;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_escapes.size() == 0)
            begin
                $display("%t: unexpected result, actual count %0d inside %0b", $realtime,
                         m_axis_tdata[15:0], m_axis_tdata[16]);
                errors++;
            end
            else
            begin
                exp_res = pending_escapes.pop_front();
                if (m_axis_tdata[15:0] !== exp_res[15:0])
                begin
                    $display("%t: escape_count expected %0d actual %0d", $realtime,
                             exp_res[15:0], m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[16] !== exp_res[16])
                begin
                    $display("%t: inside_set expected %0b actual %0b", $realtime,
                             exp_res[16], m_axis_tdata[16]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no item moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL escape_time_fractal_pixel");
            $finish;
        end
    end

    // Reset defaults: corners, centre and a second in-set point on the real axis.
    task automatic test_reset_defaults;
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd384, 10'd512);
        drain();
    endtask

    // Zero limit, full limit on the fixed point at the origin, and threshold extremes.
    task automatic test_iteration_limits;
        write_reg(REG_ITER_LIMIT, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd700, 10'd300);
        drain();
        write_reg(REG_ITER_LIMIT, 32'hFFFF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();
        write_reg(REG_ITER_LIMIT, 32'd20);
        write_reg(REG_THRESHOLD, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd600, 10'd500);
        drain();
        write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();
    endtask

    // Saturating zoom and extreme offsets.
    task automatic test_saturation;
        write_reg(REG_THRESHOLD, 32'h40000000);
        write_reg(REG_ZOOM, 32'hFFFFFFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();
        write_reg(REG_ZOOM, 32'd0);
        write_reg(REG_OFF_RE, 32'h80000000);
        write_reg(REG_OFF_IM, 32'h7FFFFFFF);
        send_pixel(10'd512, 10'd512);
        drain();
        write_reg(REG_OFF_RE, 32'h7FFFFFFF);
        write_reg(REG_OFF_IM, 32'h80000000);
        send_pixel(10'd100, 10'd900);
        drain();
    endtask

    // Julia mode with a classic constant.
    task automatic test_julia;
        write_reg(REG_ZOOM, 32'h10000000);
        write_reg(REG_OFF_RE, 32'd0);
        write_reg(REG_OFF_IM, 32'd0);
        write_reg(REG_JULIA_MODE, 32'd1);
        write_reg(REG_JULIA_RE, 32'hF3333334);  // about -0.8
        write_reg(REG_JULIA_IM, 32'h027EF9DB);  // about 0.156
        write_reg(REG_ITER_LIMIT, 32'd48);
        send_random(30, 0, 1023);
        drain();
    endtask

    // Hold the receiver off while the sender keeps offering items.
    task automatic test_backpressure;
        write_reg(REG_JULIA_MODE, 32'd0);
        write_reg(REG_ITER_LIMIT, 32'd8);
        tx_idle_on = 1'b0;
        rx_long_hold = 1'b1;
        send_random(12, 0, 1023);
        tx_idle_on = 1'b1;
        drain();
    endtask

    // Random phases over the register space, with pauses until the block drains.
    task automatic test_random_phases;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_JULIA_MODE, $urandom_range(1, 0));
            write_reg(REG_JULIA_RE, $urandom_range(32'h0C000000, 0) - 32'h06000000);
            write_reg(REG_JULIA_IM, $urandom_range(32'h0C000000, 0) - 32'h06000000);
            if (ph == 7)
            begin
                // wild settings, short limit
                write_reg(REG_ZOOM, $urandom);
                write_reg(REG_OFF_RE, $urandom);
                write_reg(REG_OFF_IM, $urandom);
                write_reg(REG_THRESHOLD, $urandom);
                write_reg(REG_ITER_LIMIT, $urandom_range(20, 0));
            end
            else
            begin
                write_reg(REG_ZOOM, $urandom_range(32'h20000000, 32'h00400000));
                write_reg(REG_OFF_RE, $urandom_range(32'h10000000, 0) - 32'h0C000000);
                write_reg(REG_OFF_IM, $urandom_range(32'h08000000, 0) - 32'h04000000);
                write_reg(REG_THRESHOLD, $urandom_range(32'h60000000, 32'h10000000));
                write_reg(REG_ITER_LIMIT, $urandom_range(64, 1));
            end
            tx_idle_on = 1'($urandom_range(1, 0));
            rx_idle_on = (ph % 3) != 0;
            send_random(25, 0, 1023);
            drain();
            send_random(25, 0, 1023);
            drain();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_JULIA_MODE;
        cfg_data = '0;
        mdl_julia = 1'b0;
        mdl_zoom = 32'h10000000;
        mdl_off_re = '0;
        mdl_off_im = '0;
        mdl_jul_re = '0;
        mdl_jul_im = '0;
        mdl_limit = 16'd64;
        mdl_thresh = 32'h40000000;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_iteration_limits();
        test_saturation();
        test_julia();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (40) @(negedge clk);
        if (errors == 0 && pending_escapes.size() == 0)
            $display("PASS escape_time_fractal_pixel");
        else
            $display("FAIL escape_time_fractal_pixel");
        $finish;
    end

endmodule
